FILE: rtl/kset_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kset_pkg
// Shared widths, codes and the queue item type of the key state tracker.
// ---------------------------------------------------------------------------
package kset_pkg;

    localparam int KEY_W      = 8;
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int ST_W       = 2;
    localparam int CNT_W      = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // request commands
    localparam logic [CMD_W-1:0] CMD_EVENT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;

    // key event kinds
    localparam logic [KIND_W-1:0] KIND_UP   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOWN = 2'd1;

    // per-key state codes
    localparam logic [ST_W-1:0] ST_NOT_HELD = 2'd0;
    localparam logic [ST_W-1:0] ST_PRESSED  = 2'd1;
    localparam logic [ST_W-1:0] ST_HELD     = 2'd2;
    localparam logic [ST_W-1:0] ST_RELEASED = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT     = 4'd3;

    // classified operations handed from front to back
    localparam logic [1:0] OP_UP    = 2'd0;
    localparam logic [1:0] OP_DOWN  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPW     = 1;
    localparam int QCW     = 2;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
    } t_item;

endpackage

FILE: rtl/key_state_edge_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_state_edge_tracker
// Per-key pressed/held/released tracking with a count of keys down.
// ---------------------------------------------------------------------------
// Each request gives one result. A key event is a read-modify-write of the
// key's entry, then four lookups of the key and the three modifiers on the
// single read port of the state memory; a query makes only the four lookups.
// A frame tick sweeps the whole memory, one entry per cycle, then makes the
// same four lookups. After reset a clearing pass zeroes the memory; requests
// are stalled during it while configuration writes are taken. A two-entry
// request queue lets new requests in while the back end works or while a
// result waits on the output register.
module key_state_edge_tracker #(
    parameter int NUM_KEYS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [kset_pkg::CMD_W-1:0]       i_cmd,
    input  logic [kset_pkg::KEY_W-1:0]       i_key_index,
    input  logic [kset_pkg::KIND_W-1:0]      i_event_kind,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [kset_pkg::ST_W-1:0]        o_key_state,
    output logic                             o_key_is_down,
    output logic                             o_any_down,
    output logic                             o_any_non_modifier_down,
    output logic [kset_pkg::CNT_W-1:0]       o_keys_down,
    input  logic                             i_cfg_we,
    input  logic [kset_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kset_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic            q_valid;
    kset_pkg::t_item q_item;
    logic            q_pop;
    logic            clearing;

    kset_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_key_index  (i_key_index),
        .i_event_kind (i_event_kind),
        .i_hold       (clearing),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    kset_back #(
        .NUM_KEYS (NUM_KEYS)
    ) u_back (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_q_valid               (q_valid),
        .i_q_item                (q_item),
        .o_q_pop                 (q_pop),
        .o_clearing              (clearing),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .o_out_valid             (o_out_valid),
        .i_out_stall             (i_out_stall),
        .o_key_state             (o_key_state),
        .o_key_is_down           (o_key_is_down),
        .o_any_down              (o_any_down),
        .o_any_non_modifier_down (o_any_non_modifier_down),
        .o_keys_down             (o_keys_down)
    );

endmodule

FILE: rtl/kset_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kset_front
// Accepts requests, classifies them into operations and queues them.
// ---------------------------------------------------------------------------
module kset_front #(
    parameter int NUM_KEYS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [kset_pkg::CMD_W-1:0]    i_cmd,
    input  logic [kset_pkg::KEY_W-1:0]    i_key_index,
    input  logic [kset_pkg::KIND_W-1:0]   i_event_kind,
    input  logic                          i_hold,
    output logic                          o_q_valid,
    output kset_pkg::t_item               o_q_item,
    input  logic                          i_q_pop
);

    localparam int IW   = $clog2(NUM_KEYS + 1);
    localparam int CMPW = (IW > kset_pkg::KEY_W) ? IW : kset_pkg::KEY_W;

    kset_pkg::t_item                 r_q [kset_pkg::Q_DEPTH];
    logic [kset_pkg::QPW-1:0]        r_wp, n_wp;
    logic [kset_pkg::QPW-1:0]        r_rp, n_rp;
    logic [kset_pkg::QCW-1:0]        r_cnt, n_cnt;
    kset_pkg::t_item                 item;
    logic                            push;
    logic                            pop;
    logic                            in_rng;

    assign o_in_stall = (r_cnt == kset_pkg::QCW'(kset_pkg::Q_DEPTH)) || i_hold;
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_item   = r_q[r_rp];

    assign in_rng = CMPW'(i_key_index) < CMPW'(NUM_KEYS);

    always_comb begin
        item.key = i_key_index;
        priority if (i_cmd == kset_pkg::CMD_EVENT && in_rng &&
                     i_event_kind == kset_pkg::KIND_DOWN) begin
            item.op = kset_pkg::OP_DOWN;
        end else if (i_cmd == kset_pkg::CMD_EVENT && in_rng &&
                     i_event_kind == kset_pkg::KIND_UP) begin
            item.op = kset_pkg::OP_UP;
        end else if (i_cmd == kset_pkg::CMD_TICK) begin
            item.op = kset_pkg::OP_TICK;
        end else begin
            // queries, repeats, odd kinds, out-of-range key events: report only
            item.op = kset_pkg::OP_QUERY;
        end
    end

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + kset_pkg::QCW'(push) - kset_pkg::QCW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

endmodule

FILE: rtl/kset_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kset_back
// Runs queued operations against the key state memory and the down count,
// and holds the result register.
// ---------------------------------------------------------------------------
module kset_back #(
    parameter int NUM_KEYS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  kset_pkg::t_item                  i_q_item,
    output logic                             o_q_pop,
    output logic                             o_clearing,
    input  logic                             i_cfg_we,
    input  logic [kset_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kset_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [kset_pkg::ST_W-1:0]        o_key_state,
    output logic                             o_key_is_down,
    output logic                             o_any_down,
    output logic                             o_any_non_modifier_down,
    output logic [kset_pkg::CNT_W-1:0]       o_keys_down
);

    localparam int AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int IW   = $clog2(NUM_KEYS + 1);
    localparam int CMPW = (IW > kset_pkg::KEY_W) ? IW : kset_pkg::KEY_W;
    localparam int KW   = kset_pkg::KEY_W;
    localparam int SW   = kset_pkg::ST_W;
    localparam int CW   = kset_pkg::CNT_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EV_RD = 3'd2;
    localparam logic [2:0] S_EV_WR = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_RES   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [2:0] PH_KEY   = 3'd0;
    localparam logic [2:0] PH_CTRL  = 3'd1;
    localparam logic [2:0] PH_SHIFT = 3'd2;
    localparam logic [2:0] PH_ALT   = 3'd3;
    localparam logic [2:0] PH_LAST  = 3'd4;

    logic [SW-1:0] mem [NUM_KEYS];

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pend_addr, n_pend_addr;
    logic [2:0]    r_ph, n_ph;
    logic [1:0]    r_op, n_op;
    logic [KW-1:0] r_key, n_key;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_rd_data;
    logic          r_rd_ok;
    logic [SW-1:0] r_ks, n_ks;
    logic          r_m_ctrl, n_m_ctrl;
    logic          r_m_shift, n_m_shift;
    logic          r_m_alt, n_m_alt;
    logic [KW-1:0] r_unk, r_ctl, r_shf, r_alt;

    logic          r_o_valid, n_o_valid;
    logic [SW-1:0] r_o_state, n_o_state;
    logic          r_o_down, n_o_down;
    logic          r_o_any, n_o_any;
    logic          r_o_nonmod, n_o_nonmod;
    logic [CW-1:0] r_o_count, n_o_count;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] wr_data;
    logic [KW-1:0] rd_code;
    logic          rd_data_down;
    logic [1:0]    mods;

    function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] c);
        return (c < kset_pkg::CNT_MAX) ? c + 1'b1 : c;
    endfunction

    function automatic logic [CW-1:0] cnt_dec(input logic [CW-1:0] c);
        return (c != '0) ? c - 1'b1 : c;
    endfunction

    assign o_clearing   = (r_state == S_CLEAR);
    assign rd_data_down = r_rd_ok && (r_rd_data == kset_pkg::ST_PRESSED ||
                                      r_rd_data == kset_pkg::ST_HELD);
    assign mods = {1'b0, r_m_ctrl} + {1'b0, r_m_shift} + {1'b0, r_m_alt};

    always_comb begin
        unique case (r_ph)
            PH_KEY:   rd_code = r_key;
            PH_CTRL:  rd_code = r_ctl;
            PH_SHIFT: rd_code = r_shf;
            default:  rd_code = r_alt;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_ph        = r_ph;
        n_op        = r_op;
        n_key       = r_key;
        n_count     = r_count;
        n_ks        = r_ks;
        n_m_ctrl    = r_m_ctrl;
        n_m_shift   = r_m_shift;
        n_m_alt     = r_m_alt;
        n_o_valid   = r_o_valid && i_out_stall;
        n_o_state   = r_o_state;
        n_o_down    = r_o_down;
        n_o_any     = r_o_any;
        n_o_nonmod  = r_o_nonmod;
        n_o_count   = r_o_count;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = kset_pkg::ST_NOT_HELD;
        o_q_pop     = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                n_idx   = r_idx + 1'b1;
                if (r_idx == IW'(NUM_KEYS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_item.op;
                    n_key   = i_q_item.key;
                    n_ph    = PH_KEY;
                    unique case (i_q_item.op)
                        kset_pkg::OP_UP,
                        kset_pkg::OP_DOWN:  n_state = S_EV_RD;
                        kset_pkg::OP_TICK: begin
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = S_SWEEP;
                        end
                        kset_pkg::OP_QUERY: n_state = S_RES;
                    endcase
                end
            end
            S_EV_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_key);
                n_state = S_EV_WR;
            end
            S_EV_WR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_key);
                wr_data = r_rd_data;
                if (r_op == kset_pkg::OP_DOWN) begin
                    if (r_rd_data == kset_pkg::ST_NOT_HELD ||
                        r_rd_data == kset_pkg::ST_RELEASED) begin
                        wr_data = kset_pkg::ST_PRESSED;
                        if (r_key != r_unk) begin
                            n_count = cnt_inc(r_count);
                        end
                    end else if (r_rd_data == kset_pkg::ST_PRESSED) begin
                        wr_data = kset_pkg::ST_HELD;
                    end
                end else begin
                    if (r_rd_data == kset_pkg::ST_RELEASED) begin
                        wr_data = kset_pkg::ST_NOT_HELD;
                        if (r_key != r_unk) begin
                            n_count = cnt_dec(r_count);
                        end
                    end else if (r_rd_data != kset_pkg::ST_NOT_HELD) begin
                        wr_data = kset_pkg::ST_RELEASED;
                    end
                end
                n_state = S_RES;
            end
            S_SWEEP: begin
                // read entry idx while writing back the one read last cycle
                if (r_idx != IW'(NUM_KEYS)) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_idx[AW-1:0];
                    n_idx       = r_idx + 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_RES;
                    end
                end
                if (r_pend) begin
                    wr_addr = r_pend_addr;
                    if (r_rd_data == kset_pkg::ST_PRESSED) begin
                        wr_en   = 1'b1;
                        wr_data = kset_pkg::ST_HELD;
                    end else if (r_rd_data == kset_pkg::ST_RELEASED) begin
                        wr_en   = 1'b1;
                        wr_data = kset_pkg::ST_NOT_HELD;
                        if (CMPW'(r_pend_addr) != CMPW'(r_unk)) begin
                            n_count = cnt_dec(r_count);
                        end
                    end
                end
            end
            S_RES: begin
                // one lookup per cycle: key, control, shift, alt
                if (r_ph != PH_LAST) begin
                    rd_en   = CMPW'(rd_code) < CMPW'(NUM_KEYS);
                    rd_addr = AW'(rd_code);
                end
                unique case (r_ph)
                    PH_KEY:   ;
                    PH_CTRL:  n_ks = r_rd_ok ? r_rd_data : kset_pkg::ST_NOT_HELD;
                    PH_SHIFT: n_m_ctrl = rd_data_down;
                    PH_ALT:   n_m_shift = rd_data_down;
                    default:  n_m_alt = rd_data_down;
                endcase
                if (r_ph == PH_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_ph = r_ph + 1'b1;
                end
            end
            S_OUT: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_state  = r_ks;
                    n_o_down   = (r_ks == kset_pkg::ST_PRESSED) ||
                                 (r_ks == kset_pkg::ST_HELD);
                    n_o_any    = (r_count != '0);
                    n_o_nonmod = (r_count != '0) && (r_count != CW'(mods));
                    n_o_count  = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_ph      <= PH_KEY;
            r_count   <= '0;
            r_rd_ok   <= 1'b0;
            r_o_valid <= 1'b0;
            r_unk     <= '0;
            r_ctl     <= '0;
            r_shf     <= '0;
            r_alt     <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_ph      <= n_ph;
            r_count   <= n_count;
            r_rd_ok   <= rd_en;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    kset_pkg::CFG_UNKNOWN: r_unk <= i_cfg_data;
                    kset_pkg::CFG_CONTROL: r_ctl <= i_cfg_data;
                    kset_pkg::CFG_SHIFT:   r_shf <= i_cfg_data;
                    kset_pkg::CFG_ALT:     r_alt <= i_cfg_data;
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_op        <= n_op;
        r_key       <= n_key;
        r_ks        <= n_ks;
        r_m_ctrl    <= n_m_ctrl;
        r_m_shift   <= n_m_shift;
        r_m_alt     <= n_m_alt;
        r_o_state   <= n_o_state;
        r_o_down    <= n_o_down;
        r_o_any     <= n_o_any;
        r_o_nonmod  <= n_o_nonmod;
        r_o_count   <= n_o_count;
    end

    // key state memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_out_valid             = r_o_valid;
    assign o_key_state             = r_o_state;
    assign o_key_is_down           = r_o_down;
    assign o_any_down              = r_o_any;
    assign o_any_non_modifier_down = r_o_nonmod;
    assign o_keys_down             = r_o_count;

endmodule

FILE: rtl/kset_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kset_checker
// Port-level checks on the key state tracker, bound to the top level.
// ---------------------------------------------------------------------------
module kset_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [kset_pkg::ST_W-1:0]        o_key_state,
    input logic                             o_key_is_down,
    input logic                             o_any_down,
    input logic                             o_any_non_modifier_down,
    input logic [kset_pkg::CNT_W-1:0]       o_keys_down
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_key_state) &&
            $stable(o_key_is_down) && $stable(o_keys_down) &&
            $stable(o_any_down) && $stable(o_any_non_modifier_down))
        else $error("stalled result changed");

    // reset starts the clearing pass: no requests, no results
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("block not quiet after reset");

    // summary flags agree with the reported count
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_any_down == (o_keys_down != '0)) &&
            (!o_any_non_modifier_down || o_any_down))
        else $error("summary flags disagree with count");

    // the key's down flag follows its reported state
    a_key_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_key_is_down == (o_key_state == kset_pkg::ST_PRESSED ||
            o_key_state == kset_pkg::ST_HELD))
        else $error("key down flag disagrees with key state");

endmodule

bind key_state_edge_tracker kset_checker u_kset_checker (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .o_in_stall              (o_in_stall),
    .o_out_valid             (o_out_valid),
    .i_out_stall             (i_out_stall),
    .o_key_state             (o_key_state),
    .o_key_is_down           (o_key_is_down),
    .o_any_down              (o_any_down),
    .o_any_non_modifier_down (o_any_non_modifier_down),
    .o_keys_down             (o_keys_down)
);

FILE: tb/key_state_edge_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_state_edge_tracker_test
// Self-checking bench for the key state tracker. Directed and random key
// events, frame ticks and queries are sent under several key code settings.
// Each result is checked field by field against an in-bench tracker of the
// per-key states and the down count. Both sides idle at random, and a long
// output stall fills the block.
// ----------------------------------------------------------------------------
module key_state_edge_tracker_test;

    localparam int KEY_COUNT     = 256;
    localparam int SETTLE_CYCLES = 300;
    localparam int CMD_W         = kset_pkg::CMD_W;
    localparam int KEY_W         = kset_pkg::KEY_W;
    localparam int KIND_W        = kset_pkg::KIND_W;
    localparam int ST_W          = kset_pkg::ST_W;
    localparam int CNT_W         = kset_pkg::CNT_W;

    localparam logic [CMD_W-1:0]  CMD_QUERY     = 2'd2;
    localparam logic [CMD_W-1:0]  CMD_QUERY_ALT = 2'd3;
    localparam logic [KIND_W-1:0] KIND_REPEAT   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE    = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]  state;
        logic             is_down;
        logic             any_down;
        logic             non_mod_down;
        logic [CNT_W-1:0] count;
    } t_key_report;

    logic                                i_clk        = 1'b0;
    logic                                i_rst_n      = 1'b0;
    logic                                i_in_valid   = 1'b0;
    logic                                o_in_stall;
    logic [CMD_W-1:0]                    i_cmd        = '0;
    logic [KEY_W-1:0]                    i_key_index  = '0;
    logic [KIND_W-1:0]                   i_event_kind = '0;
    logic                                o_out_valid;
    logic                                i_out_stall  = 1'b0;
    logic [ST_W-1:0]                     o_key_state;
    logic                                o_key_is_down;
    logic                                o_any_down;
    logic                                o_any_non_modifier_down;
    logic [CNT_W-1:0]                    o_keys_down;
    logic                                i_cfg_we     = 1'b0;
    logic [kset_pkg::CFG_IDX_W-1:0]      i_cfg_index  = '0;
    logic [kset_pkg::CFG_DATA_W-1:0]     i_cfg_data   = '0;

    // tracker state
    logic [ST_W-1:0]  model_keys [KEY_COUNT];
    logic [CNT_W-1:0] model_count;
    logic [KEY_W-1:0] reg_unknown, reg_control, reg_shift, reg_alt;
    t_key_report      pending_reports [$];

    bit source_jitter = 1'b1;
    bit sink_jitter   = 1'b1;
    int sink_hold     = 0;

    int error_count     = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int ticks_sent      = 0;
    int settings_loaded = 0;
    int peak_count      = 0;

    key_state_edge_tracker #(
        .NUM_KEYS(KEY_COUNT)
    ) i_dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_in_valid              (i_in_valid),
        .o_in_stall              (o_in_stall),
        .i_cmd                   (i_cmd),
        .i_key_index             (i_key_index),
        .i_event_kind            (i_event_kind),
        .o_out_valid             (o_out_valid),
        .i_out_stall             (i_out_stall),
        .o_key_state             (o_key_state),
        .o_key_is_down           (o_key_is_down),
        .o_any_down              (o_any_down),
        .o_any_non_modifier_down (o_any_non_modifier_down),
        .o_keys_down             (o_keys_down),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < 30) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        end
        error_count++;
    endtask

    function automatic logic key_down_in_model(input logic [KEY_W-1:0] key);
        return (model_keys[key] == kset_pkg::ST_PRESSED) ||
               (model_keys[key] == kset_pkg::ST_HELD);
    endfunction

    // Advance the tracker by one accepted request and queue its report.
    task automatic track_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                 input logic [KIND_W-1:0] kind);
        t_key_report rep;
        logic [1:0]  mods;
        if (cmd == kset_pkg::CMD_EVENT) begin
            if (kind == kset_pkg::KIND_DOWN) begin
                if (model_keys[key] == kset_pkg::ST_NOT_HELD ||
                    model_keys[key] == kset_pkg::ST_RELEASED) begin
                    model_keys[key] = kset_pkg::ST_PRESSED;
                    if (key != reg_unknown && model_count != kset_pkg::CNT_MAX) model_count++;
                end else if (model_keys[key] == kset_pkg::ST_PRESSED) begin
                    model_keys[key] = kset_pkg::ST_HELD;
                end
            end else if (kind == kset_pkg::KIND_UP) begin
                if (model_keys[key] == kset_pkg::ST_RELEASED) begin
                    model_keys[key] = kset_pkg::ST_NOT_HELD;
                    if (key != reg_unknown && model_count != '0) model_count--;
                end else if (model_keys[key] != kset_pkg::ST_NOT_HELD) begin
                    model_keys[key] = kset_pkg::ST_RELEASED;
                end
            end
        end else if (cmd == kset_pkg::CMD_TICK) begin
            ticks_sent++;
            for (int k = 0; k < KEY_COUNT; k++) begin
                if (model_keys[k] == kset_pkg::ST_PRESSED) begin
                    model_keys[k] = kset_pkg::ST_HELD;
                end else if (model_keys[k] == kset_pkg::ST_RELEASED) begin
                    model_keys[k] = kset_pkg::ST_NOT_HELD;
                    if (k != reg_unknown && model_count != '0) model_count--;
                end
            end
        end
        // a key named by two modifier codes counts twice
        mods = {1'b0, key_down_in_model(reg_control)} + {1'b0, key_down_in_model(reg_shift)}
             + {1'b0, key_down_in_model(reg_alt)};
        rep.state        = model_keys[key];
        rep.is_down      = key_down_in_model(key);
        rep.any_down     = (model_count != '0);
        rep.non_mod_down = (model_count != '0) && (int'(mods) != int'(model_count));
        rep.count        = model_count;
        pending_reports.push_back(rep);
        if (int'(model_count) > peak_count) peak_count = int'(model_count);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                input logic [KIND_W-1:0] kind);
        int gap;
        gap = source_jitter ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_key_index  <= key;
        i_event_kind <= kind;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_request(cmd, key, kind);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Hold the input idle until every pending result has arrived.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_key_codes(input logic [KEY_W-1:0] unknown_code,
                                  input logic [KEY_W-1:0] control_code,
                                  input logic [KEY_W-1:0] shift_code,
                                  input logic [KEY_W-1:0] alt_code);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= kset_pkg::CFG_UNKNOWN;
        i_cfg_data  <= unknown_code;
        @(negedge i_clk);
        i_cfg_index <= kset_pkg::CFG_CONTROL;
        i_cfg_data  <= control_code;
        @(negedge i_clk);
        i_cfg_index <= kset_pkg::CFG_SHIFT;
        i_cfg_data  <= shift_code;
        @(negedge i_clk);
        i_cfg_index <= kset_pkg::CFG_ALT;
        i_cfg_data  <= alt_code;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        reg_unknown = unknown_code;
        reg_control = control_code;
        reg_shift   = shift_code;
        reg_alt     = alt_code;
        settings_loaded++;
    endtask

    task automatic test_directed_events();
        drain_block();
        load_key_codes(8'hFF, 8'h00, 8'h10, 8'h80);
        send_request(CMD_QUERY, 8'h00, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_EVENT, 8'h00, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_EVENT, 8'h00, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_EVENT, 8'h00, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_EVENT, 8'h55, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_EVENT, 8'h55, KIND_REPEAT);
        send_request(kset_pkg::CMD_EVENT, 8'h55, KIND_SPARE);
        send_request(kset_pkg::CMD_EVENT, 8'h55, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_EVENT, 8'h55, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_EVENT, 8'h55, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_EVENT, 8'h55, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_EVENT, 8'h55, kset_pkg::KIND_UP);
        // the unknown key moves through its states but is never counted
        send_request(kset_pkg::CMD_EVENT, 8'hFF, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_EVENT, 8'hFF, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_TICK, 8'hFF, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_EVENT, 8'hAA, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_EVENT, 8'hAA, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_TICK, 8'hAA, KIND_SPARE);
        send_request(kset_pkg::CMD_EVENT, 8'h10, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_TICK, 8'h10, kset_pkg::KIND_DOWN);
        send_request(CMD_QUERY_ALT, 8'h10, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_EVENT, 8'h10, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_EVENT, 8'h00, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_TICK, 8'h00, KIND_REPEAT);
    endtask

    // A key pressed while it was the unknown key, released after the code moved.
    task automatic test_count_floor();
        drain_block();
        load_key_codes(8'h33, 8'h00, 8'h10, 8'h80);
        send_request(kset_pkg::CMD_EVENT, 8'h33, kset_pkg::KIND_DOWN);
        drain_block();
        load_key_codes(8'h34, 8'h00, 8'h10, 8'h80);
        send_request(kset_pkg::CMD_EVENT, 8'h34, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_EVENT, 8'h33, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_EVENT, 8'h33, kset_pkg::KIND_UP);
        drain_block();
        load_key_codes(8'hFF, 8'h00, 8'h10, 8'h80);
        send_request(kset_pkg::CMD_EVENT, 8'h34, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_TICK, 8'h34, kset_pkg::KIND_UP);
    endtask

    task automatic test_modifier_overlap();
        drain_block();
        load_key_codes(8'h00, 8'h07, 8'h07, 8'h09);
        send_request(kset_pkg::CMD_EVENT, 8'h07, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_EVENT, 8'h09, kset_pkg::KIND_DOWN);
        send_request(CMD_QUERY, 8'h09, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_EVENT, 8'h07, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_EVENT, 8'h09, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_TICK, 8'h07, kset_pkg::KIND_UP);
        drain_block();
        // unknown key doubling as a modifier: down but not counted
        load_key_codes(8'h09, 8'h07, 8'h08, 8'h09);
        send_request(kset_pkg::CMD_EVENT, 8'h09, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_EVENT, 8'h20, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_EVENT, 8'h08, kset_pkg::KIND_DOWN);
        send_request(kset_pkg::CMD_TICK, 8'h09, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_EVENT, 8'h09, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_EVENT, 8'h20, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_EVENT, 8'h08, kset_pkg::KIND_UP);
        send_request(kset_pkg::CMD_TICK, 8'h20, kset_pkg::KIND_UP);
    endtask

    task automatic test_backpressure();
        logic [KEY_W-1:0] key;
        drain_block();
        source_jitter = 1'b0;
        sink_jitter   = 1'b0;
        sink_hold     = 200;
        for (int n = 0; n < 17; n++) begin
            key = 8'h40 + KEY_W'(n % 8);
            if (n == 8) send_request(kset_pkg::CMD_TICK, key, kset_pkg::KIND_UP);
            else send_request(kset_pkg::CMD_EVENT, key,
                              (n < 8) ? kset_pkg::KIND_DOWN : kset_pkg::KIND_UP);
        end
        drain_block();
        source_jitter = 1'b1;
        sink_jitter   = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [KEY_W-1:0] pool [8];
        logic [KEY_W-1:0] ctrl_code;
        logic [KEY_W-1:0] key;
        int               pick;
        for (int phase = 0; phase < 6; phase++) begin
            drain_block();
            ctrl_code = KEY_W'($urandom_range(0, 255));
            case (phase)
                0: load_key_codes(8'h00, 8'h01, 8'h02, 8'h03);
                1: load_key_codes(8'hFF, 8'hFE, 8'hFF, 8'h80);
                default: begin
                    load_key_codes(KEY_W'($urandom_range(0, 255)), ctrl_code,
                                   ($urandom_range(0, 3) == 0) ? ctrl_code
                                                               : KEY_W'($urandom_range(0, 255)),
                                   KEY_W'($urandom_range(0, 255)));
                end
            endcase
            pool[0] = reg_unknown;
            pool[1] = reg_control;
            pool[2] = reg_shift;
            pool[3] = reg_alt;
            for (int p = 4; p < 8; p++) pool[p] = KEY_W'($urandom_range(0, 255));
            source_jitter = (phase % 3 != 2);
            sink_jitter   = (phase % 3 != 1);
            for (int n = 0; n < 120; n++) begin
                // mostly a small set of keys so that each walks its whole cycle
                key  = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)]
                                                  : KEY_W'($urandom_range(0, 255));
                pick = $urandom_range(0, 99);
                if (pick < 45) send_request(kset_pkg::CMD_EVENT, key, kset_pkg::KIND_DOWN);
                else if (pick < 78) send_request(kset_pkg::CMD_EVENT, key, kset_pkg::KIND_UP);
                else if (pick < 82) send_request(kset_pkg::CMD_EVENT, key,
                                                 $urandom_range(0, 1) ? KIND_REPEAT : KIND_SPARE);
                else if (pick < 90) send_request(kset_pkg::CMD_TICK, key,
                                                 KIND_W'($urandom_range(0, 3)));
                else send_request($urandom_range(0, 1) ? CMD_QUERY : CMD_QUERY_ALT, key,
                                  KIND_W'($urandom_range(0, 3)));
            end
        end
        source_jitter = 1'b1;
        sink_jitter   = 1'b1;
    endtask

    // Push the count to its ceiling: swap the unknown code between two keys so that
    // each round counts one press and loses one release.
    task automatic test_count_ceiling();
        logic [KEY_W-1:0] leak_key;
        logic [KEY_W-1:0] fill_key;
        int               extra;
        drain_block();
        load_key_codes(8'h00, 8'h03, 8'h04, 8'h05);
        for (int k = 1; k < KEY_COUNT; k++) begin
            send_request(kset_pkg::CMD_EVENT, KEY_W'(k), kset_pkg::KIND_DOWN);
        end
        extra = 0;
        for (int r = 0; r < 700 && extra < 3; r++) begin
            leak_key = (r % 2) ? 8'd2 : 8'd1;
            fill_key = (r % 2) ? 8'd1 : 8'd2;
            drain_block();
            load_key_codes(leak_key, 8'h03, 8'h04, 8'h05);
            send_request(kset_pkg::CMD_EVENT, fill_key, kset_pkg::KIND_DOWN);
            send_request(kset_pkg::CMD_EVENT, leak_key, kset_pkg::KIND_UP);
            send_request(kset_pkg::CMD_EVENT, leak_key, kset_pkg::KIND_UP);
            if (model_count == kset_pkg::CNT_MAX) extra++;
        end
    endtask

    initial begin : result_sink
        int wait_cycles;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            wait_cycles = sink_hold + (sink_jitter ? $urandom_range(0, 10) : 0);
            sink_hold   = 0;
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_key_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("result with no request pending", 1, 0);
            end else begin
                want = pending_reports.pop_front();
                results_checked++;
                if (o_key_state !== want.state)
                    report_mismatch("key_state", o_key_state, want.state);
                if (o_key_is_down !== want.is_down)
                    report_mismatch("key_is_down", o_key_is_down, want.is_down);
                if (o_any_down !== want.any_down)
                    report_mismatch("any_down", o_any_down, want.any_down);
                if (o_any_non_modifier_down !== want.non_mod_down)
                    report_mismatch("any_non_modifier_down", o_any_non_modifier_down,
                                    want.non_mod_down);
                if (o_keys_down !== want.count)
                    report_mismatch("keys_down", o_keys_down, want.count);
            end
        end
    end

    initial begin : run_tests
        foreach (model_keys[k]) model_keys[k] = kset_pkg::ST_NOT_HELD;
        model_count = '0;
        reg_unknown = '0;
        reg_control = '0;
        reg_shift   = '0;
        reg_alt     = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_events();
        test_count_floor();
        test_modifier_overlap();
        test_backpressure();
        test_random_traffic();
        test_count_ceiling();

        drain_block();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("covered %0d requests (%0d frame ticks) under %0d key code settings",
                 requests_sent, ticks_sent, settings_loaded);
        $display("checked %0d results, down count peaked at %0d", results_checked, peak_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
